[rtl/sd_card_spi_init_sequencer_defines.svh]
// assertion macros for the sd card spi start-up sequencer
// used by sd_card_spi_init_sequencer.sv, needs a clock and reset in scope
`ifndef SD_CARD_SPI_INIT_SEQUENCER_DEFINES_SVH
`define SD_CARD_SPI_INIT_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked on every rising clock outside reset
`define SDI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sdi_pkg.sv]
// shared types and constants for the sd card spi start-up sequencer
// no dependencies
package sdi_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       transfer_request;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic [2:0] status;
      logic       card_v2;
      logic       card_ccs;
   } rsp_type;

   // configuration register indexes
   localparam logic REG_RESPONSE_POLL_LIMIT = 1'b0;
   localparam logic REG_INIT_RETRY_LIMIT    = 1'b1;
   localparam logic [15:0] LIMIT_RESET      = 16'd10000;

   // request actions
   localparam logic ACT_START    = 1'b0;
   localparam logic ACT_EXCHANGE = 1'b1;

   // status codes
   localparam logic [2:0] ST_RUNNING  = 3'd0;
   localparam logic [2:0] ST_SUCCESS  = 3'd1;
   localparam logic [2:0] ST_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_BAD_RESP = 3'd3;
   localparam logic [2:0] ST_RETRIES  = 3'd4;

   // commands of the sequence
   localparam logic [2:0] CMD_GO_IDLE = 3'd0;
   localparam logic [2:0] CMD_IF_COND = 3'd1;
   localparam logic [2:0] CMD_APP     = 3'd2;
   localparam logic [2:0] CMD_OP_COND = 3'd3;
   localparam logic [2:0] CMD_OCR     = 3'd4;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] BYTE_CRC   = 8'h95;
   localparam logic [7:0] BYTE_START = 8'h40;
   localparam logic [7:0] BYTE_HCS   = 8'h40;
   localparam logic [7:0] BYTE_CHECK = 8'hAA;
   localparam logic [7:0] R1_IDLE    = 8'h01;

   function automatic logic [5:0] cmd_number(input logic [2:0] cmd);
      logic [5:0] num;
      case (cmd)
         CMD_GO_IDLE: num = 6'd0;
         CMD_IF_COND: num = 6'd8;
         CMD_APP:     num = 6'd55;
         CMD_OP_COND: num = 6'd41;
         CMD_OCR:     num = 6'd58;
         default:     num = 6'd0;
      endcase
      return num;
   endfunction

   // commands followed by four trailing response bytes
   function automatic logic cmd_long(input logic [2:0] cmd);
      return (cmd == CMD_IF_COND) || (cmd == CMD_OP_COND) || (cmd == CMD_OCR);
   endfunction

   // byte idx of the six-byte command frame
   function automatic logic [7:0] frame_byte(input logic [2:0] cmd, input logic [3:0] idx,
                                             input logic v2);
      logic [7:0] b;
      b = 8'h00;
      if (idx == 4'd0) begin
         b = BYTE_START | {2'b00, cmd_number(cmd)};
      end else if (idx >= 4'd5) begin
         b = BYTE_CRC;
      end else if (cmd == CMD_IF_COND) begin
         if (idx == 4'd3) b = 8'h01;
         else if (idx == 4'd4) b = BYTE_CHECK;
      end else if (cmd == CMD_OP_COND && idx == 4'd1) begin
         b = v2 ? BYTE_HCS : 8'h00;
      end
      return b;
   endfunction

endpackage

[rtl/sd_card_spi_init_sequencer.sv]
// sd card spi-mode start-up sequencer, one request per spi byte exchange
// depends on sdi_pkg and sd_card_spi_init_sequencer_defines.svh

// Each request is either a start or the report of a finished byte exchange
// (with the byte the card returned); each gives exactly one response that
// says whether to run another exchange, which byte to send and the select
// level, plus the final status once the sequence ends. Requests pass an
// input register, the next-state logic and an output register: one request
// per clock is taken while the output is not stalled; the response is
// registered from the input register. In a system the spi link sets the pace,
// one request per byte exchange. Limits must be written through the csr port
// while no exchange is outstanding; the block itself does not enforce this.
`include "sd_card_spi_init_sequencer_defines.svh"

module sd_card_spi_init_sequencer (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  sdi_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sdi_pkg::rsp_type rsp_data,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic [15:0]     csr_wdata
);
   import sdi_pkg::*;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_PRE_HIGH = 3'd1;
   localparam logic [2:0] PH_PRE_LOW  = 3'd2;
   localparam logic [2:0] PH_ERR      = 3'd3;
   localparam logic [2:0] PH_DONE     = 3'd4;
   localparam logic [2:0] PH_SEND     = 3'd5;
   localparam logic [2:0] PH_POLL     = 3'd6;
   localparam logic [2:0] PH_TAIL     = 3'd7;

   logic [15:0] poll_limit_ff, retry_limit_ff;
   logic        s1_vld_ff, s1_vld_in;
   req_type     s1_ff;
   logic        rsp_vld_ff, rsp_vld_in;
   rsp_type     rsp_ff, rsp_in;
   logic        out_free, process, accept;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [3:0]  bidx_ff, bidx_in;
   logic [15:0] poll_ff, poll_in;
   logic [15:0] loop_ff, loop_in;
   logic [7:0]  resp0_ff, resp0_in;
   logic [7:0]  resp1_ff, resp1_in;
   logic        v2_ff, v2_in;
   logic        ccs_ff, ccs_in;
   logic [2:0]  final_ff, final_in;

   // intents resolved in order: command end, poll, loop, start / finish
   logic        o_req, o_cs;
   logic [7:0]  o_tx;
   logic [3:0]  bidx_inc;
   logic        fc_en;
   logic [7:0]  fc_r0, fc_r1;
   logic        ready;
   logic        poll_en, loop_en, start_en, fin_en, fin_flush;
   logic [15:0] poll_base, loop_base, cnt_dec;
   logic [2:0]  loop_cmd, start_cmd, fin_code;

   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign process   = s1_vld_ff && out_free;
   assign req_stall = s1_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept || (s1_vld_ff && !process);
   assign rsp_vld_in = process || (rsp_vld_ff && rsp_stall);

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      bidx_in  = bidx_ff;
      poll_in  = poll_ff;
      loop_in  = loop_ff;
      resp0_in = resp0_ff;
      resp1_in = resp1_ff;
      v2_in    = v2_ff;
      ccs_in   = ccs_ff;
      final_in = final_ff;
      o_req = 1'b0;
      o_tx  = BYTE_IDLE;
      o_cs  = 1'b1;
      bidx_inc = 4'(bidx_ff + 4'd1);
      fc_en = 1'b0;
      fc_r0 = resp0_ff;
      fc_r1 = resp1_ff;
      poll_en = 1'b0;
      poll_base = poll_ff;
      loop_en = 1'b0;
      loop_base = loop_ff;
      loop_cmd = CMD_APP;
      start_en = 1'b0;
      start_cmd = CMD_GO_IDLE;
      fin_en = 1'b0;
      fin_flush = 1'b1;
      fin_code = ST_SUCCESS;
      cnt_dec = 16'd0;
      ready = 1'b0;

      if (s1_ff.action == ACT_START) begin
         v2_in    = 1'b0;
         ccs_in   = 1'b0;
         final_in = ST_RUNNING;
         phase_in = PH_PRE_HIGH;
         bidx_in  = 4'd0;
         o_req = 1'b1;
      end else begin
         case (phase_ff)
            PH_PRE_HIGH: begin
               o_req = 1'b1;
               if (bidx_inc < 4'd10) begin
                  bidx_in = bidx_inc;
               end else begin
                  phase_in = PH_PRE_LOW;
                  bidx_in  = 4'd0;
                  o_cs = 1'b0;
               end
            end
            PH_PRE_LOW: begin
               bidx_in = bidx_inc;
               if (bidx_inc < 4'd2) begin
                  o_req = 1'b1;
                  o_cs  = 1'b0;
               end else begin
                  start_en  = 1'b1;
                  start_cmd = CMD_GO_IDLE;
               end
            end
            PH_ERR: begin
               phase_in = PH_DONE;
            end
            PH_SEND: begin
               bidx_in = bidx_inc;
               if (bidx_inc < 4'd6) begin
                  o_req = 1'b1;
                  o_tx  = frame_byte(cmd_ff, bidx_inc, v2_ff);
                  o_cs  = 1'b0;
               end else begin
                  poll_en   = 1'b1;
                  poll_base = poll_limit_ff;
               end
            end
            PH_POLL: begin
               if (!s1_ff.rx_byte[7]) begin
                  resp0_in = s1_ff.rx_byte;
                  if (cmd_long(cmd_ff)) begin
                     phase_in = PH_TAIL;
                     bidx_in  = 4'd0;
                     o_req = 1'b1;
                     o_cs  = 1'b0;
                  end else begin
                     fc_en = 1'b1;
                     fc_r0 = s1_ff.rx_byte;
                  end
               end else begin
                  poll_en = 1'b1;
               end
            end
            PH_TAIL: begin
               // only the first trailing byte is ever examined
               if (bidx_ff[1:0] == 2'd0) resp1_in = s1_ff.rx_byte;
               bidx_in = bidx_inc;
               if (bidx_inc < 4'd4) begin
                  o_req = 1'b1;
                  o_cs  = 1'b0;
               end else begin
                  fc_en = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // end of a command: judge the response
      if (fc_en) begin
         ready = !fc_r0[0] && fc_r1[7];
         case (cmd_ff)
            CMD_GO_IDLE: begin
               if (fc_r0 != R1_IDLE) begin
                  fin_en = 1'b1;
                  fin_code = ST_BAD_RESP;
               end else begin
                  start_en  = 1'b1;
                  start_cmd = CMD_IF_COND;
               end
            end
            CMD_IF_COND: begin
               if (!fc_r0[0]) begin
                  fin_en = 1'b1;
                  fin_code = ST_BAD_RESP;
               end else begin
                  // illegal-command bit clear means a v2 card
                  if (!fc_r0[2]) v2_in = 1'b1;
                  loop_en   = 1'b1;
                  loop_base = retry_limit_ff;
                  loop_cmd  = CMD_APP;
               end
            end
            CMD_APP: begin
               start_en  = 1'b1;
               start_cmd = CMD_OP_COND;
            end
            CMD_OP_COND: begin
               if (!ready) begin
                  loop_en  = 1'b1;
                  loop_cmd = CMD_APP;
               end else if (fc_r0 != 8'h00) begin
                  fin_en = 1'b1;
                  fin_code = ST_BAD_RESP;
               end else if (v2_ff) begin
                  loop_en   = 1'b1;
                  loop_base = retry_limit_ff;
                  loop_cmd  = CMD_OCR;
               end else begin
                  fin_en = 1'b1;
                  fin_flush = 1'b0;
                  fin_code = ST_SUCCESS;
               end
            end
            default: begin
               if (!ready) begin
                  loop_en  = 1'b1;
                  loop_cmd = CMD_OCR;
               end else begin
                  ccs_in = fc_r1[6];
                  fin_en = 1'b1;
                  fin_flush = 1'b0;
                  fin_code = ST_SUCCESS;
               end
            end
         endcase
      end

      if (poll_en) begin
         cnt_dec = 16'(poll_base - 16'd1);
         poll_in = cnt_dec;
         if (cnt_dec == 16'd0) begin
            fin_en = 1'b1;
            fin_code = ST_TIMEOUT;
         end else begin
            phase_in = PH_POLL;
            o_req = 1'b1;
            o_cs  = 1'b0;
         end
      end

      if (loop_en) begin
         cnt_dec = 16'(loop_base - 16'd1);
         loop_in = cnt_dec;
         if (cnt_dec == 16'd0) begin
            fin_en = 1'b1;
            fin_code = ST_RETRIES;
         end else begin
            start_en  = 1'b1;
            start_cmd = loop_cmd;
         end
      end

      if (start_en) begin
         phase_in = PH_SEND;
         cmd_in   = start_cmd;
         bidx_in  = 4'd0;
         o_req = 1'b1;
         o_tx  = frame_byte(start_cmd, 4'd0, v2_in);
         o_cs  = 1'b0;
      end

      // an error releases select for one flush byte before reporting
      if (fin_en) begin
         final_in = fin_code;
         phase_in = fin_flush ? PH_ERR : PH_DONE;
         o_req = fin_flush;
         o_tx  = BYTE_IDLE;
         o_cs  = 1'b1;
      end

      rsp_in.transfer_request = o_req;
      rsp_in.tx_byte     = o_tx;
      rsp_in.chip_select = o_req ? o_cs : 1'b1;
      rsp_in.status      = o_req ? ST_RUNNING : final_in;
      rsp_in.card_v2     = v2_in;
      rsp_in.card_ccs    = ccs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff  <= LIMIT_RESET;
         retry_limit_ff <= LIMIT_RESET;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         phase_ff <= PH_IDLE;
         cmd_ff   <= CMD_GO_IDLE;
         bidx_ff  <= 4'd0;
         poll_ff  <= 16'd0;
         loop_ff  <= 16'd0;
         v2_ff    <= 1'b0;
         ccs_ff   <= 1'b0;
         final_ff <= ST_RUNNING;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_RESPONSE_POLL_LIMIT) poll_limit_ff <= csr_wdata;
            else retry_limit_ff <= csr_wdata;
         end
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (process) begin
            phase_ff <= phase_in;
            cmd_ff   <= cmd_in;
            bidx_ff  <= bidx_in;
            poll_ff  <= poll_in;
            loop_ff  <= loop_in;
            v2_ff    <= v2_in;
            ccs_ff   <= ccs_in;
            final_ff <= final_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) s1_ff <= req_data;
      if (process) begin
         rsp_ff   <= rsp_in;
         resp0_ff <= resp0_in;
         resp1_ff <= resp1_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `SDI_ASSERT_NEXT(a_held_request, s1_vld_ff && !out_free, s1_vld_ff, "request lost under stall")
   `SDI_ASSERT_NEXT(a_process_out, process, rsp_vld_ff, "processed request gave no response")
   `SDI_ASSERT_NOW(a_tail_index, phase_ff == PH_TAIL, bidx_ff < 4'd4, "trailing byte index overrun")
   `SDI_ASSERT_NOW(a_running_status, rsp_vld_ff && rsp_ff.transfer_request,
                   rsp_ff.status == ST_RUNNING && rsp_ff.tx_byte != 8'h00 || rsp_ff.status == ST_RUNNING,
                   "final status shown while exchanges continue")

endmodule
